### src/rrl_pkg.sv
// ----------------------------------------------------------------------------
// Run/lumi range list package
// Shared widths, codes, character constants and the types that pass between
// the front end and the back end of the range list parser.
// ----------------------------------------------------------------------------
package rrl_pkg;

   // Field widths of the item channels.
   localparam int REQ_BITS       = 2;
   localparam int CHAR_BITS      = 8;
   localparam int RUN_BITS       = 24;
   localparam int LUMI_BITS      = 16;
   localparam int STATUS_BITS    = 2;
   localparam int COUNT_OUT_BITS = 9;

   // Default table depth for the top level.
   localparam int MAX_RANGES_DEF = 256;

   // The number accumulator must hold the wider of the two number kinds.
   localparam int ACC_W     = (RUN_BITS > LUMI_BITS) ? RUN_BITS : LUMI_BITS;
   localparam int DIGIT_W   = 4;
   localparam int DIGIT_BASE = 10;

   // Depth of the queue between the front end and the back end.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_LVL_W = $clog2(QUEUE_DEPTH + 1);

   // Text characters that the parser reacts to.
   localparam logic [CHAR_BITS-1:0] CH_LBRACE = 8'h7B;
   localparam logic [CHAR_BITS-1:0] CH_RBRACE = 8'h7D;
   localparam logic [CHAR_BITS-1:0] CH_QUOTE  = 8'h22;
   localparam logic [CHAR_BITS-1:0] CH_COLON  = 8'h3A;
   localparam logic [CHAR_BITS-1:0] CH_LBRACK = 8'h5B;
   localparam logic [CHAR_BITS-1:0] CH_RBRACK = 8'h5D;
   localparam logic [CHAR_BITS-1:0] CH_COMMA  = 8'h2C;
   localparam logic [CHAR_BITS-1:0] CH_ZERO   = 8'h30;
   localparam logic [CHAR_BITS-1:0] CH_NINE   = 8'h39;
   localparam logic [CHAR_BITS-1:0] CH_SPACE  = 8'h20;
   localparam logic [CHAR_BITS-1:0] CH_TAB    = 8'h09;
   localparam logic [CHAR_BITS-1:0] CH_CR     = 8'h0D;

   typedef enum logic [REQ_BITS-1:0] {
      REQ_LOAD  = 2'd0,
      REQ_QUERY = 2'd1,
      REQ_CLEAR = 2'd2,
      REQ_NOP   = 2'd3
   } req_kind_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_BUSY  = 2'd0,
      ST_DONE  = 2'd1,
      ST_ERROR = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      CC_SPACE  = 4'd0,
      CC_DIGIT  = 4'd1,
      CC_LBRACE = 4'd2,
      CC_RBRACE = 4'd3,
      CC_QUOTE  = 4'd4,
      CC_COLON  = 4'd5,
      CC_LBRACK = 4'd6,
      CC_RBRACK = 4'd7,
      CC_COMMA  = 4'd8,
      CC_OTHER  = 4'd9
   } char_class_type;

   // One classified item as it waits in the queue.
   typedef struct packed {
      req_kind_type           kind;
      char_class_type         cclass;
      logic [DIGIT_W-1:0]     digit;
      logic [RUN_BITS-1:0]    run;
      logic [LUMI_BITS-1:0]   lumi;
   } work_item_type;

   // Head of the queue as the back end sees it.
   typedef struct packed {
      logic          valid;
      work_item_type item;
   } fq_head_type;

   // One stored range record.
   typedef struct packed {
      logic [RUN_BITS-1:0]  run;
      logic [LUMI_BITS-1:0] first;
      logic [LUMI_BITS-1:0] last;
   } range_rec_type;

endpackage

### src/rrl_if.sv
// ----------------------------------------------------------------------------
// Run/lumi range list channels
// Valid/ready channels for request items and response items.
// ----------------------------------------------------------------------------
interface rrl_req_if;
   logic                             valid;
   logic                             ready;
   logic [rrl_pkg::REQ_BITS-1:0]     req_type;
   logic [rrl_pkg::CHAR_BITS-1:0]    char_code;
   logic [rrl_pkg::RUN_BITS-1:0]     query_run;
   logic [rrl_pkg::LUMI_BITS-1:0]    query_lumi;

   modport source(output valid, output req_type, output char_code, output query_run,
                  output query_lumi, input ready);
   modport sink(input valid, input req_type, input char_code, input query_run,
                input query_lumi, output ready);
endinterface

interface rrl_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                hit;
   logic [rrl_pkg::STATUS_BITS-1:0]     parse_status;
   logic [rrl_pkg::COUNT_OUT_BITS-1:0]  ranges_stored;

   modport source(output valid, output hit, output parse_status, output ranges_stored,
                  input ready);
   modport sink(input valid, input hit, input parse_status, input ranges_stored,
                output ready);
endinterface

### src/rrl_front.sv
// ----------------------------------------------------------------------------
// Run/lumi range list front end
// Accepts request items, classifies the text character and queues the item.
// ----------------------------------------------------------------------------
module rrl_front (
   input  logic                 clock,
   input  logic                 reset,
   rrl_req_if.sink              req_ch,
   output rrl_pkg::fq_head_type head,
   input  logic                 pop
);

   function automatic rrl_pkg::char_class_type classify(
      input logic [rrl_pkg::CHAR_BITS-1:0] c);
      rrl_pkg::char_class_type cc;
      priority if (c == rrl_pkg::CH_SPACE || (c >= rrl_pkg::CH_TAB && c <= rrl_pkg::CH_CR))
         cc = rrl_pkg::CC_SPACE;
      else if (c >= rrl_pkg::CH_ZERO && c <= rrl_pkg::CH_NINE)
         cc = rrl_pkg::CC_DIGIT;
      else if (c == rrl_pkg::CH_LBRACE) cc = rrl_pkg::CC_LBRACE;
      else if (c == rrl_pkg::CH_RBRACE) cc = rrl_pkg::CC_RBRACE;
      else if (c == rrl_pkg::CH_QUOTE)  cc = rrl_pkg::CC_QUOTE;
      else if (c == rrl_pkg::CH_COLON)  cc = rrl_pkg::CC_COLON;
      else if (c == rrl_pkg::CH_LBRACK) cc = rrl_pkg::CC_LBRACK;
      else if (c == rrl_pkg::CH_RBRACK) cc = rrl_pkg::CC_RBRACK;
      else if (c == rrl_pkg::CH_COMMA)  cc = rrl_pkg::CC_COMMA;
      else                              cc = rrl_pkg::CC_OTHER;
      return cc;
   endfunction

   rrl_pkg::work_item_type                q_mem_ff [rrl_pkg::QUEUE_DEPTH];
   logic [rrl_pkg::QUEUE_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [rrl_pkg::QUEUE_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [rrl_pkg::QUEUE_LVL_W-1:0]       level_ff, level_in;
   rrl_pkg::work_item_type                new_item;
   logic [rrl_pkg::CHAR_BITS-1:0]         digit_full;
   logic                                  push;

   always_comb begin
      digit_full        = req_ch.char_code - rrl_pkg::CH_ZERO;
      new_item.kind     = rrl_pkg::req_kind_type'(req_ch.req_type);
      new_item.cclass   = classify(req_ch.char_code);
      new_item.digit    = digit_full[rrl_pkg::DIGIT_W-1:0];
      new_item.run      = req_ch.query_run;
      new_item.lumi     = req_ch.query_lumi;
   end

   assign req_ch.ready = (level_ff != rrl_pkg::QUEUE_LVL_W'(rrl_pkg::QUEUE_DEPTH));
   assign push         = req_ch.valid && req_ch.ready;

   assign head.valid = (level_ff != '0);
   assign head.item  = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == rrl_pkg::QUEUE_PTR_W'(rrl_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == rrl_pkg::QUEUE_PTR_W'(rrl_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   level_in = level_ff + 1'b1;
         2'b01:   level_in = level_ff - 1'b1;
         default: level_in = level_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

### src/rrl_back.sv
// ----------------------------------------------------------------------------
// Run/lumi range list back end
// Runs the text parser, keeps the range table and scans it for queries.
// ----------------------------------------------------------------------------
module rrl_back #(
   parameter int MAX_RANGES = rrl_pkg::MAX_RANGES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rrl_pkg::fq_head_type head,
   output logic                 pop,
   rrl_rsp_if.source            rsp_ch
);

   localparam int ADDR_W    = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int CNT_W     = $clog2(MAX_RANGES + 1);
   localparam int ACC_EXT_W = rrl_pkg::ACC_W + 4;

   typedef enum logic [6:0] {
      PH_EXPECT_BRACE = 7'b0000001,
      PH_NEED_RUN     = 7'b0000010,
      PH_HAVE_RUN     = 7'b0000100,
      PH_OUTER        = 7'b0001000,
      PH_INNER_FIRST  = 7'b0010000,
      PH_INNER_LAST   = 7'b0100000,
      PH_DONE         = 7'b1000000
   } phase_type;

   typedef enum logic [2:0] {
      CTL_IDLE = 3'b001,
      CTL_SCAN = 3'b010,
      CTL_WAIT = 3'b100
   } ctl_type;

   rrl_pkg::range_rec_type               range_mem [MAX_RANGES];

   ctl_type                              ctl_ff, ctl_in;
   phase_type                            phase_ff, phase_in;
   logic                                 quotes_ff, quotes_in;
   logic [rrl_pkg::ACC_W-1:0]            acc_ff, acc_in;
   logic [rrl_pkg::RUN_BITS-1:0]         cur_run_ff, cur_run_in;
   logic [rrl_pkg::LUMI_BITS-1:0]        start_ff, start_in;
   rrl_pkg::status_type                  status_ff, status_in;
   logic [CNT_W-1:0]                     count_ff, count_in;

   logic [rrl_pkg::RUN_BITS-1:0]         q_run_ff, q_run_in;
   logic [rrl_pkg::LUMI_BITS-1:0]        q_lumi_ff, q_lumi_in;
   logic [CNT_W-1:0]                     idx_ff, idx_in;
   rrl_pkg::range_rec_type               rd_rec_ff;
   logic                                 cmp_valid_ff, cmp_valid_in;
   logic                                 cmp_last_ff, cmp_last_in;
   logic                                 hit_acc_ff, hit_acc_in;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 rsp_hit_ff, rsp_hit_in;
   rrl_pkg::status_type                  rsp_status_ff, rsp_status_in;
   logic [rrl_pkg::COUNT_OUT_BITS-1:0]   rsp_count_ff, rsp_count_in;

   logic                                 take;
   logic                                 wr_en;
   rrl_pkg::range_rec_type               wr_rec;
   logic [ACC_EXT_W-1:0]                 acc_next;
   logic [ACC_EXT_W-1:0]                 digit_limit;
   logic                                 rec_match;
   logic                                 scan_start;
   logic                                 scan_last;

   assign take = (ctl_ff == CTL_IDLE) && head.valid && (!rsp_valid_ff || rsp_ch.ready);
   assign pop  = take;

   // ---- parser ----
   always_comb begin
      phase_in    = phase_ff;
      quotes_in   = quotes_ff;
      acc_in      = acc_ff;
      cur_run_in  = cur_run_ff;
      start_in    = start_ff;
      status_in   = status_ff;
      count_in    = count_ff;
      wr_en       = 1'b0;
      wr_rec.run   = cur_run_ff;
      wr_rec.first = start_ff;
      wr_rec.last  = acc_ff[rrl_pkg::LUMI_BITS-1:0];
      acc_next    = ACC_EXT_W'(acc_ff) * ACC_EXT_W'(rrl_pkg::DIGIT_BASE) +
                    ACC_EXT_W'(head.item.digit);
      digit_limit = quotes_ff ? ACC_EXT_W'({rrl_pkg::RUN_BITS{1'b1}}) :
                                ACC_EXT_W'({rrl_pkg::LUMI_BITS{1'b1}});

      if (take && head.item.kind == rrl_pkg::REQ_CLEAR) begin
         phase_in   = PH_EXPECT_BRACE;
         quotes_in  = 1'b0;
         acc_in     = '0;
         cur_run_in = '0;
         start_in   = '0;
         status_in  = rrl_pkg::ST_BUSY;
         count_in   = '0;
      end else if (take && head.item.kind == rrl_pkg::REQ_LOAD &&
                   status_ff == rrl_pkg::ST_BUSY && head.item.cclass != rrl_pkg::CC_SPACE) begin
         if (quotes_ff) begin
            priority if (head.item.cclass == rrl_pkg::CC_QUOTE) begin
               cur_run_in = acc_ff[rrl_pkg::RUN_BITS-1:0];
               quotes_in  = 1'b0;
               phase_in   = PH_HAVE_RUN;
            end else if (head.item.cclass == rrl_pkg::CC_DIGIT) begin
               acc_in = acc_next[rrl_pkg::ACC_W-1:0];
               if (acc_next > digit_limit) status_in = rrl_pkg::ST_ERROR;
            end else begin
               status_in = rrl_pkg::ST_ERROR;
            end
         end else begin
            unique case (phase_ff)
               PH_EXPECT_BRACE: begin
                  if (head.item.cclass == rrl_pkg::CC_LBRACE) phase_in = PH_NEED_RUN;
                  else status_in = rrl_pkg::ST_ERROR;
               end
               PH_NEED_RUN: begin
                  priority if (head.item.cclass == rrl_pkg::CC_QUOTE) begin
                     quotes_in = 1'b1;
                     acc_in    = '0;
                  end else if (head.item.cclass == rrl_pkg::CC_RBRACE) begin
                     phase_in  = PH_DONE;
                     status_in = rrl_pkg::ST_DONE;
                  end else if (head.item.cclass != rrl_pkg::CC_COMMA &&
                               head.item.cclass != rrl_pkg::CC_COLON) begin
                     status_in = rrl_pkg::ST_ERROR;
                  end
               end
               PH_HAVE_RUN: begin
                  priority if (head.item.cclass == rrl_pkg::CC_LBRACK) begin
                     phase_in = PH_OUTER;
                  end else if (head.item.cclass != rrl_pkg::CC_COMMA &&
                               head.item.cclass != rrl_pkg::CC_COLON) begin
                     status_in = rrl_pkg::ST_ERROR;
                  end
               end
               PH_OUTER: begin
                  priority if (head.item.cclass == rrl_pkg::CC_LBRACK) begin
                     phase_in = PH_INNER_FIRST;
                     acc_in   = '0;
                  end else if (head.item.cclass == rrl_pkg::CC_RBRACK) begin
                     phase_in = PH_NEED_RUN;
                  end else if (head.item.cclass != rrl_pkg::CC_COMMA) begin
                     status_in = rrl_pkg::ST_ERROR;
                  end
               end
               PH_INNER_FIRST: begin
                  priority if (head.item.cclass == rrl_pkg::CC_DIGIT) begin
                     acc_in = acc_next[rrl_pkg::ACC_W-1:0];
                     if (acc_next > digit_limit) status_in = rrl_pkg::ST_ERROR;
                  end else if (head.item.cclass == rrl_pkg::CC_COMMA) begin
                     start_in = acc_ff[rrl_pkg::LUMI_BITS-1:0];
                     acc_in   = '0;
                     phase_in = PH_INNER_LAST;
                  end else begin
                     status_in = rrl_pkg::ST_ERROR;
                  end
               end
               PH_INNER_LAST: begin
                  priority if (head.item.cclass == rrl_pkg::CC_DIGIT) begin
                     acc_in = acc_next[rrl_pkg::ACC_W-1:0];
                     if (acc_next > digit_limit) status_in = rrl_pkg::ST_ERROR;
                  end else if (head.item.cclass == rrl_pkg::CC_RBRACK) begin
                     if (count_ff == CNT_W'(MAX_RANGES)) begin
                        status_in = rrl_pkg::ST_ERROR;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                        phase_in = PH_OUTER;
                     end
                  end else begin
                     status_in = rrl_pkg::ST_ERROR;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   // ---- query scan and response register ----
   assign rec_match = (rd_rec_ff.run == q_run_ff) && (rd_rec_ff.first <= q_lumi_ff) &&
                      (q_lumi_ff <= rd_rec_ff.last);
   assign scan_start = take && head.item.kind == rrl_pkg::REQ_QUERY &&
                       status_ff == rrl_pkg::ST_DONE && count_ff != '0;
   assign scan_last  = (idx_ff == count_ff - 1'b1);

   always_comb begin
      ctl_in        = ctl_ff;
      q_run_in      = q_run_ff;
      q_lumi_in     = q_lumi_ff;
      idx_in        = idx_ff;
      cmp_valid_in  = 1'b0;
      cmp_last_in   = 1'b0;
      hit_acc_in    = hit_acc_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_hit_in    = rsp_hit_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;

      unique case (ctl_ff)
         CTL_IDLE: begin
            if (scan_start) begin
               ctl_in     = CTL_SCAN;
               q_run_in   = head.item.run;
               q_lumi_in  = head.item.lumi;
               idx_in     = '0;
               hit_acc_in = 1'b0;
            end else if (take) begin
               rsp_valid_in  = 1'b1;
               rsp_hit_in    = 1'b0;
               rsp_status_in = status_in;
               rsp_count_in  = rrl_pkg::COUNT_OUT_BITS'(count_in);
            end
         end
         CTL_SCAN: begin
            cmp_valid_in = 1'b1;
            cmp_last_in  = scan_last;
            idx_in       = idx_ff + 1'b1;
            if (scan_last) ctl_in = CTL_WAIT;
         end
         CTL_WAIT: begin
            ctl_in = CTL_WAIT;
         end
         default: begin
            ctl_in = CTL_IDLE;
         end
      endcase

      if (cmp_valid_ff) begin
         hit_acc_in = hit_acc_ff | rec_match;
         if (cmp_last_ff) begin
            ctl_in        = CTL_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_hit_in    = hit_acc_ff | rec_match;
            rsp_status_in = status_ff;
            rsp_count_in  = rrl_pkg::COUNT_OUT_BITS'(count_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff       <= CTL_IDLE;
         phase_ff     <= PH_EXPECT_BRACE;
         quotes_ff    <= 1'b0;
         acc_ff       <= '0;
         cur_run_ff   <= '0;
         start_ff     <= '0;
         status_ff    <= rrl_pkg::ST_BUSY;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ctl_ff       <= ctl_in;
         phase_ff     <= phase_in;
         quotes_ff    <= quotes_in;
         acc_ff       <= acc_in;
         cur_run_ff   <= cur_run_in;
         start_ff     <= start_in;
         status_ff    <= status_in;
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q_run_ff      <= q_run_in;
      q_lumi_ff     <= q_lumi_in;
      idx_ff        <= idx_in;
      cmp_last_ff   <= cmp_last_in;
      hit_acc_ff    <= hit_acc_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // Range table: one write port for the parser, one registered read port for the scan.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         range_mem[count_ff[ADDR_W-1:0]] <= wr_rec;
      end
      if (ctl_ff == CTL_SCAN) begin
         rd_rec_ff <= range_mem[idx_ff[ADDR_W-1:0]];
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.hit           = rsp_hit_ff;
   assign rsp_ch.parse_status  = rsp_status_ff;
   assign rsp_ch.ranges_stored = rsp_count_ff;

endmodule

### src/run_range_list_parser_and_lookup.sv
// ----------------------------------------------------------------------------
// Run/lumi range list parser and lookup
// Parses a run/lumi range list text one character per item into a range
// table and answers run/section queries against it.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake     | Payload
//   --------+-----------+---------------+------------------------------------
//   req_ch  | in        | valid / ready | req_type, char_code, query_run,
//           |           |               | query_lumi
//   rsp_ch  | out       | valid / ready | hit, parse_status, ranges_stored
//
// Every request item gives exactly one response item, in order.
// Load, clear and no-op items are answered without a scan; a query on a
// completed parse reads the stored records one per cycle through the single
// read port of the range table.
// Reset is synchronous and active high; the table needs no clearing pass,
// since only records below the stored count are ever read.
// The two-entry queue keeps taking items, until it is full, while the back end
// scans or while a response waits for rsp_ch.ready.
// ----------------------------------------------------------------------------
module run_range_list_parser_and_lookup #(
   parameter int MAX_RANGES = rrl_pkg::MAX_RANGES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   rrl_req_if.sink     req_ch,
   rrl_rsp_if.source   rsp_ch
);

   // Head of the item queue and the pop strobe between the two halves.
   rrl_pkg::fq_head_type head;
   logic                 pop;

   // The front end classifies each character once and buffers the item.
   rrl_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .head   (head),
      .pop    (pop)
   );

   // The back end owns the parser state, the range table and the response register.
   rrl_back #(
      .MAX_RANGES (MAX_RANGES)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

   // The back end must never take an item from an empty queue.
   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("item taken from an empty queue");

   // A query can only hit once the text has been parsed completely.
   a_hit_needs_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.hit) |-> (rsp_ch.parse_status == rrl_pkg::ST_DONE))
      else $error("hit reported without a complete parse");

   // Reset leaves no response pending and no item being taken.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!rsp_ch.valid && !pop))
      else $error("response or pop right after reset");

endmodule
